@@ sv/gbn_pkg.sv @@
// Shared constants, types and tap lookup for the 9x9 border-normalised Gaussian blur.
package gbn_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned RADIUS    = 4;
  localparam int unsigned TAPS      = 2 * RADIUS + 1;
  localparam int unsigned RING_ROWS = 4 * RADIUS;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W    = $clog2(RING_ROWS);
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned WID_W     = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned WT_W      = 16;
  localparam int unsigned NTAP      = 5;
  localparam int unsigned TAPS_LW   = $clog2(TAPS);
  localparam int unsigned VS_W      = WT_W + PIX_W + TAPS_LW;
  localparam int unsigned GS_W      = WT_W + TAPS_LW;
  localparam int unsigned WS_W      = 2 * GS_W;
  localparam int unsigned ACC_W     = VS_W + WT_W + TAPS_LW;
  localparam int unsigned QB        = 8;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WT_W-1:0]  wt_t;
  typedef wt_t [NTAP-1:0]   taps_t;

  // Token handed from cell to cell down the vertical chain
  typedef struct packed {
    logic                  vld;
    wt_t                   gx;
    logic [VS_W-1:0]       sum;
    pix_t [TAPS-1:0]       pix;
  } vtok_t;

  // One-dimensional weight at distance d; zero beyond the last tap
  function automatic wt_t tap_at(taps_t t, logic [3:0] d);
    wt_t r;
    r = '0;
    if (int'(d) < NTAP) r = t[d[2:0]];
    return r;
  endfunction

endpackage

@@ sv/gbn_lmem.sv @@
// Line store: one word per column holding every ring row, byte-wide writes, registered read.
module gbn_lmem (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [gbn_pkg::COL_W-1:0]                   waddr_i,
  input  logic [gbn_pkg::SLOT_W-1:0]                  wslot_i,
  input  gbn_pkg::pix_t                               wdata_i,
  input  logic [gbn_pkg::COL_W-1:0]                   raddr_i,
  output gbn_pkg::pix_t [gbn_pkg::RING_ROWS-1:0]      rdata_o
);
  import gbn_pkg::*;

  pix_t [RING_ROWS-1:0] mem_q [MAX_WIDTH];
  pix_t [RING_ROWS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wslot_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gbn_cell.sv @@
// One vertical cell: adds its row weight times the lowest pixel, shifts the pixels on.
module gbn_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbn_pkg::wt_t   gy_i,
  input  gbn_pkg::vtok_t tok_i,
  output gbn_pkg::vtok_t tok_o
);
  import gbn_pkg::*;

  vtok_t tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.vld <= tok_i.vld;
      tok_q.gx  <= tok_i.gx;
      tok_q.sum <= tok_i.sum + VS_W'(gy_i) * VS_W'(tok_i.pix[0]);
      for (int i = 0; i < TAPS - 1; i++) begin
        tok_q.pix[i] <= tok_i.pix[i+1];
      end
      tok_q.pix[TAPS-1] <= '0;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ sv/gbn_div.sv @@
// Restoring divider, one quotient bit a cycle; quotient known to fit in QB bits.
module gbn_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gbn_pkg::ACC_W-1:0] dvd_i,
  input  logic [gbn_pkg::WS_W-1:0]  dvs_i,
  output logic                      done_o,
  output logic [gbn_pkg::QB-1:0]    quo_o
);
  import gbn_pkg::*;

  localparam int unsigned CNT_W = $clog2(QB);

  logic             busy_q, done_q, zero_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] rem_q, dsh_q;
  logic [QB-1:0]    quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        zero_q <= (dvs_i == '0);
        cnt_q  <= CNT_W'(QB - 1);
        rem_q  <= dvd_i;
        dsh_q  <= ACC_W'(dvs_i) << (QB - 1);
        quo_q  <= '0;
      end else if (busy_q) begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[QB-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QB-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : quo_q;

endmodule

@@ sv/gaussian_9x9_border_normalized.sv @@
// Top level of the streaming 9x9 Gaussian blur with border normalisation.
// Gray pixels arrive in raster order; each result is the weighted mean of the in-frame
// neighbours within four rows and columns, divided by the weights actually used and
// truncated, and lags the input by four rows plus four pixels. tuser = 1 marks a flush
// transfer: after a frame's last pixel, each flush drains one pending result, the final
// one with tlast set; pixels sent while draining are dropped. One item is worked on at a
// time. For a pixel with a result and for a flush, nine line-store reads, one per window
// column, stream through a chain of nine vertical multiply-add cells, a horizontal
// multiply-add follows, then an 8-step divider and the load of the output register.
// The next item is taken while a result waits on the output register. Configuration
// writes must go in only while the block is idle; the block does not enforce this.
module gaussian_9x9_border_normalized (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic        s_axis_tuser,   // [0] mode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast
);
  import gbn_pkg::*;

  localparam int unsigned PROD_W = ROW_W + WID_W;
  localparam int unsigned POS_W  = PROD_W + 1;
  localparam int unsigned IX_W   = $clog2(TAPS);
  localparam int unsigned HC_W   = $clog2(TAPS + 1);

  typedef enum logic [2:0] {
    REG_WIDTH, REG_HEIGHT, REG_WT0, REG_WT1, REG_WT2, REG_WT3, REG_WT4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_PREP, S_ISSUE, S_WAIT, S_WSUM, S_DIV, S_PUSH
  } state_e;

  // configuration
  logic [WID_W-1:0] wid_q;
  logic [ROW_W-1:0] hgt_q;
  taps_t            wt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= WID_W'(1024);
      hgt_q <= ROW_W'(1024);
      wt_q  <= taps_t'({WT_W{1'b1}});
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:  wid_q   <= cfg_data_i[WID_W-1:0];
        REG_HEIGHT: hgt_q   <= cfg_data_i[ROW_W-1:0];
        REG_WT0:    wt_q[0] <= cfg_data_i;
        REG_WT1:    wt_q[1] <= cfg_data_i;
        REG_WT2:    wt_q[2] <= cfg_data_i;
        REG_WT3:    wt_q[3] <= cfg_data_i;
        REG_WT4:    wt_q[4] <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  logic [WID_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    if (wid_q == '0)                      w_eff = WID_W'(1);
    else if (wid_q > WID_W'(MAX_WIDTH))   w_eff = WID_W'(MAX_WIDTH);
    else                                  w_eff = wid_q;
    h_eff = (hgt_q == '0) ? ROW_W'(1) : hgt_q;
  end

  state_e            state_q;
  logic [COL_W-1:0]  in_col_q, out_col_q, fcol_q;
  logic [ROW_W-1:0]  in_row_q, out_row_q, frow_q;
  logic              drain_q, flast_q;
  logic [PROD_W-1:0] prod_q;
  logic [IX_W-1:0]   ix_q;
  logic [HC_W-1:0]   hcnt_q;
  wt_t [TAPS-1:0]    gy_q;
  logic [GS_W-1:0]   gys_q, gxs_q;
  logic [ACC_W-1:0]  acc_q;
  logic              rd_vld_q;
  wt_t               rd_gx_q;
  logic              m_vld_q, m_last_q;
  pix_t              m_data_q;
  logic              push;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // raster counter advance
  logic [WID_W-1:0] in_col_inc, out_col_inc;
  logic [ROW_W:0]   in_row_inc, out_row_inc;
  logic             in_col_end, in_last, out_col_end, out_last;
  logic [COL_W-1:0] in_col_adv, out_col_adv;
  logic [ROW_W-1:0] in_row_adv, out_row_adv;
  logic [POS_W-1:0] pos, lag;

  always_comb begin
    in_col_inc  = WID_W'(in_col_q) + WID_W'(1);
    in_row_inc  = (ROW_W+1)'(in_row_q) + (ROW_W+1)'(1);
    in_col_end  = in_col_inc >= w_eff;
    in_last     = in_col_end && (in_row_inc >= (ROW_W+1)'(h_eff));
    in_col_adv  = in_col_end ? '0 : in_col_inc[COL_W-1:0];
    in_row_adv  = in_col_end ? in_row_inc[ROW_W-1:0] : in_row_q;
    out_col_inc = WID_W'(out_col_q) + WID_W'(1);
    out_row_inc = (ROW_W+1)'(out_row_q) + (ROW_W+1)'(1);
    out_col_end = out_col_inc >= w_eff;
    out_last    = out_col_end && (out_row_inc >= (ROW_W+1)'(h_eff));
    out_col_adv = out_col_end ? '0 : out_col_inc[COL_W-1:0];
    out_row_adv = out_col_end ? out_row_inc[ROW_W-1:0] : out_row_q;
    pos = POS_W'(prod_q) + POS_W'(in_col_q);
    lag = POS_W'(w_eff) * POS_W'(RADIUS) + POS_W'(RADIUS);
  end

  // row weights of the window, zero for rows outside the frame
  wt_t [TAPS-1:0]  gy_c;
  logic [GS_W-1:0] gys_c;

  always_comb begin
    logic signed [ROW_W+1:0] r;
    gys_c = '0;
    for (int k = 0; k < TAPS; k++) begin
      r = signed'((ROW_W+2)'(frow_q)) + (ROW_W+2)'(k) - (ROW_W+2)'(RADIUS);
      if (r >= 0 && r < signed'((ROW_W+2)'(h_eff))) begin
        gy_c[k] = tap_at(wt_q, (k >= RADIUS) ? 4'(k - RADIUS) : 4'(RADIUS - k));
      end else begin
        gy_c[k] = '0;
      end
      gys_c = gys_c + GS_W'(gy_c[k]);
    end
  end

  // column read issue
  logic signed [COL_W+1:0] col_s;
  logic [COL_W-1:0]        raddr;
  logic [3:0]              dx_abs;
  wt_t                     gx_c;
  logic                    issue;

  always_comb begin
    col_s  = signed'((COL_W+2)'(fcol_q)) + (COL_W+2)'(ix_q) - (COL_W+2)'(RADIUS);
    raddr  = col_s[COL_W-1:0];
    dx_abs = (ix_q >= IX_W'(RADIUS)) ? 4'(ix_q - IX_W'(RADIUS)) : 4'(IX_W'(RADIUS) - ix_q);
    issue  = (state_q == S_ISSUE);
    if (col_s >= 0 && col_s < signed'((COL_W+2)'(w_eff))) gx_c = tap_at(wt_q, dx_abs);
    else                                                  gx_c = '0;
  end

  pix_t [RING_ROWS-1:0] rdata;

  gbn_lmem u_lmem (
    .clk_i   (clk_i),
    .we_i    (s_acc && !s_axis_tuser && !drain_q),
    .waddr_i (in_col_q),
    .wslot_i (in_row_q[SLOT_W-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // vertical chain
  vtok_t chain [TAPS+1];
  vtok_t tok0;

  always_comb begin
    logic [SLOT_W-1:0] slot;
    tok0.vld = rd_vld_q;
    tok0.gx  = rd_gx_q;
    tok0.sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      slot = frow_q[SLOT_W-1:0] + SLOT_W'(k) - SLOT_W'(RADIUS);
      // zero-weight taps may sit on words never written; keep them out of the sums
      tok0.pix[k] = (rd_gx_q == '0 || gy_q[k] == '0) ? '0 : rdata[slot];
    end
  end

  assign chain[0] = tok0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    gbn_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .gy_i   (gy_q[k]),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  logic         div_done;
  logic [QB-1:0] div_quo;

  gbn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_WSUM),
    .dvd_i   (acc_q),
    .dvs_i   (WS_W'(gxs_q) * WS_W'(gys_q)),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign push = (state_q == S_PUSH) && (!m_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      drain_q   <= 1'b0;
      fcol_q    <= '0;
      frow_q    <= '0;
      flast_q   <= 1'b0;
      prod_q    <= '0;
      ix_q      <= '0;
      hcnt_q    <= '0;
      gy_q      <= '0;
      gys_q     <= '0;
      gxs_q     <= '0;
      acc_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_gx_q   <= '0;
      m_vld_q   <= 1'b0;
      m_last_q  <= 1'b0;
      m_data_q  <= '0;
    end else begin
      rd_vld_q <= issue;
      rd_gx_q  <= gx_c;
      if (push) begin
        m_vld_q  <= 1'b1;
        m_data_q <= div_quo;
        m_last_q <= flast_q;
      end else if (m_vld_q && m_axis_tready) begin
        m_vld_q <= 1'b0;
      end

      // horizontal multiply-add at the end of the chain
      if (chain[TAPS].vld) begin
        acc_q  <= acc_q + ACC_W'(chain[TAPS].gx) * ACC_W'(chain[TAPS].sum);
        gxs_q  <= gxs_q + GS_W'(chain[TAPS].gx);
        hcnt_q <= hcnt_q + HC_W'(1);
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            if (!s_axis_tuser) begin
              if (!drain_q) begin
                prod_q  <= PROD_W'(in_row_q) * PROD_W'(w_eff);
                state_q <= S_DECIDE;
              end
            end else if (drain_q) begin
              frow_q  <= out_row_q;
              fcol_q  <= out_col_q;
              flast_q <= out_last;
              if (out_last) begin
                in_col_q  <= '0;
                in_row_q  <= '0;
                out_col_q <= '0;
                out_row_q <= '0;
                drain_q   <= 1'b0;
              end else begin
                out_col_q <= out_col_adv;
                out_row_q <= out_row_adv;
              end
              state_q <= S_PREP;
            end
          end
        end
        S_DECIDE: begin
          in_col_q <= in_col_adv;
          in_row_q <= in_row_adv;
          if (in_last) drain_q <= 1'b1;
          if (pos >= lag) begin
            frow_q    <= out_row_q;
            fcol_q    <= out_col_q;
            flast_q   <= 1'b0;
            out_col_q <= out_col_adv;
            out_row_q <= out_row_adv;
            state_q   <= S_PREP;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_PREP: begin
          gy_q    <= gy_c;
          gys_q   <= gys_c;
          gxs_q   <= '0;
          acc_q   <= '0;
          hcnt_q  <= '0;
          ix_q    <= '0;
          state_q <= S_ISSUE;
        end
        S_ISSUE: begin
          ix_q <= ix_q + IX_W'(1);
          if (ix_q == IX_W'(TAPS - 1)) state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (hcnt_q == HC_W'(TAPS)) state_q <= S_WSUM;
        end
        S_WSUM: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (push) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

@@ sv/gbn_chk.sv @@
// Port-level checker for the Gaussian blur top level, with its bind.
module gbn_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // output register empty straight out of reset
  a_rst_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a new result only appears after a busy cycle, never straight from idle
  a_busy_before: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without work");

endmodule

bind gaussian_9x9_border_normalized gbn_chk u_gbn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ verif/gaussian_9x9_border_normalized_tb.sv @@
// Self-checking testbench for the streaming 9x9 border-normalised Gaussian blur.
module gaussian_9x9_border_normalized_tb;
  import gbn_pkg::*;

  typedef enum logic {MODE_PIXEL = 1'b0, MODE_FLUSH = 1'b1} mode_e;
  typedef enum logic [2:0] {
    REG_WIDTH = 3'd0, REG_HEIGHT = 3'd1, REG_TAP0 = 3'd2, REG_TAP1 = 3'd3,
    REG_TAP2 = 3'd4, REG_TAP3 = 3'd5, REG_TAP4 = 3'd6
  } reg_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    mode_e      mode;
    logic [7:0] pix;
  } stim_t;

  typedef struct {
    logic [7:0] pix;
    logic       last;
  } blur_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] pixel_in
  logic        s_axis_tuser;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] pixel_out
  logic        m_axis_tlast;

  gaussian_9x9_border_normalized uut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  ring [RING_ROWS][MAX_WIDTH];
  int unsigned in_row, in_col, out_row, out_col;
  bit          draining;
  logic [10:0] geo_width;
  logic [11:0] geo_height;
  logic [15:0] gtap [NTAP];

  stim_t       stim_q[$];
  blur_res_t   blur_q[$];
  stim_t       cur;
  blur_res_t   want;
  idle_e       idle_sel;
  int          errors;
  bit          hold_req, hold_taken;
  int          hold_left;

  function automatic int unsigned eff_w();
    if (geo_width == 0) return 1;
    if (geo_width > MAX_WIDTH) return MAX_WIDTH;
    return geo_width;
  endfunction

  function automatic int unsigned eff_h();
    return (geo_height == 0) ? 1 : geo_height;
  endfunction

  function automatic logic [7:0] blur_at(int unsigned orow, int unsigned ocol,
                                         int unsigned w, int unsigned h);
    longint unsigned acc, wsum, wt;
    int r, c;
    acc = 0;
    wsum = 0;
    for (int dy = -4; dy <= 4; dy++) begin
      r = int'(orow) + dy;
      if (r < 0 || r >= int'(h)) continue;
      for (int dx = -4; dx <= 4; dx++) begin
        c = int'(ocol) + dx;
        if (c < 0 || c >= int'(w)) continue;
        wt = 64'(gtap[dx < 0 ? -dx : dx]) * 64'(gtap[dy < 0 ? -dy : dy]);
        acc += 64'(ring[r % RING_ROWS][c]) * wt;
        wsum += wt;
      end
    end
    if (wsum == 0) return 8'd0;
    return 8'(acc / wsum);
  endfunction

  // raster step; true when the position stood at the frame's last pixel
  function automatic bit raster_step(ref int unsigned row, ref int unsigned col,
                                     input int unsigned w, input int unsigned h);
    bit at_end;
    at_end = (row + 1 >= h) && (col + 1 >= w);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1) & 32'hFFF;
    end else begin
      col = col + 1;
    end
    return at_end;
  endfunction

  task automatic predict_item(mode_e mode, logic [7:0] pix);
    int unsigned w, h;
    logic [7:0] v;
    bit last;
    w = eff_w();
    h = eff_h();
    if (mode == MODE_PIXEL) begin
      if (draining) return;
      ring[in_row % RING_ROWS][in_col] = pix;
      if (in_row * w + in_col >= 4 * w + 4) begin
        v = blur_at(out_row, out_col, w, h);
        void'(raster_step(out_row, out_col, w, h));
        blur_q.push_back('{v, 1'b0});
      end
      if (raster_step(in_row, in_col, w, h)) draining = 1;
    end else if (draining) begin
      v = blur_at(out_row, out_col, w, h);
      last = raster_step(out_row, out_col, w, h);
      blur_q.push_back('{v, last});
      if (last) begin
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        draining = 0;
      end
    end
  endtask

  function automatic bit pick(int pct_idle);
    return $urandom_range(99) >= pct_idle;
  endfunction

  // pixel driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_item(mode_e'(s_axis_tuser), s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_q.size() > 0 && (idle_sel == IDLE_SEND ? pick(78) :
                                  idle_sel == IDLE_BOTH ? pick(10) : 1'b1)) begin
          cur = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur.pix;
          s_axis_tuser  <= cur.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blur_q.size() == 0) begin
          $display("%0t: unexpected transfer pix=%0d last=%0b", $time,
                   m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = blur_q.pop_front();
          if (m_axis_tdata !== want.pix || m_axis_tlast !== want.last) begin
            $display("%0t: mismatch expected pix=%0d last=%0b actual pix=%0d last=%0b",
                     $time, want.pix, want.last, m_axis_tdata, m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
        m_axis_tready <= 1'b0;
        hold_left <= 400;
        hold_taken <= 1'b1;
      end else begin
        m_axis_tready <= idle_sel == IDLE_RECV ? pick(78) :
                         idle_sel == IDLE_BOTH ? pick(10) : 1'b1;
      end
    end
  end

  task automatic cfg_write(reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_WIDTH:  geo_width = val[10:0];
      REG_HEIGHT: geo_height = val[11:0];
      default:    gtap[idx - REG_TAP0] = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_taps(int kind);
    for (int i = 0; i < NTAP; i++) begin
      case (kind)
        0: cfg_write(reg_e'(REG_TAP0 + i), 16'($urandom));
        1: cfg_write(reg_e'(REG_TAP0 + i), 16'hFFFF >> (2 * i));
        2: cfg_write(reg_e'(REG_TAP0 + i), 16'h0);
        3: cfg_write(reg_e'(REG_TAP0 + i), 16'hFFFF);
        default: cfg_write(reg_e'(REG_TAP0 + i), $urandom_range(3) == 0 ? 16'h0 :
                           16'($urandom_range(1, 65535)));
      endcase
    end
  endtask

  task automatic wait_idle();
    while (stim_q.size() > 0 || s_axis_tvalid || blur_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one whole frame at the current geometry, then flushes to drain it; noisy adds stray flushes and pixels
  task automatic push_frame(bit noisy);
    int unsigned w, h, npix, lag, drain;
    w = eff_w();
    h = eff_h();
    npix = w * h;
    lag = 4 * w + 4;
    drain = npix < lag ? npix : lag;
    if (noisy) repeat ($urandom_range(2)) stim_q.push_back('{MODE_FLUSH, rand_pix()});
    repeat (npix) stim_q.push_back('{MODE_PIXEL, rand_pix()});
    repeat (drain) begin
      if (noisy && $urandom_range(5) == 0) stim_q.push_back('{MODE_PIXEL, rand_pix()});
      stim_q.push_back('{MODE_FLUSH, rand_pix()});
    end
  endtask

  task automatic run_frame(logic [10:0] w, logic [11:0] h, int taps, bit noisy);
    wait_idle();
    cfg_write(REG_WIDTH, 16'(w));
    cfg_write(REG_HEIGHT, 16'(h));
    set_taps(taps);
    push_frame(noisy);
  endtask

  initial begin
    int pushed;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_WIDTH;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= MODE_PIXEL;
    m_axis_tready <= 1'b0;
    idle_sel = IDLE_NONE;
    errors = 0;
    hold_req = 0;
    hold_taken = 0;
    hold_left = 0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    draining = 0;
    geo_width = 11'd1024;
    geo_height = 12'd1024;
    gtap = '{16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero geometry acts as 1x1; stray flush ignored, pixel during drain dropped
    cfg_write(REG_WIDTH, 16'h0);
    cfg_write(REG_HEIGHT, 16'h0);
    stim_q.push_back('{MODE_FLUSH, 8'h00});
    stim_q.push_back('{MODE_PIXEL, 8'hFF});
    stim_q.push_back('{MODE_PIXEL, 8'h00});
    stim_q.push_back('{MODE_FLUSH, 8'hFF});
    // all weights zero gives zero
    wait_idle();
    cfg_write(REG_WIDTH, 16'd3);
    cfg_write(REG_HEIGHT, 16'd2);
    set_taps(2);
    stim_q.push_back('{MODE_PIXEL, 8'hFF});
    stim_q.push_back('{MODE_PIXEL, 8'h00});
    stim_q.push_back('{MODE_PIXEL, 8'hAA});
    stim_q.push_back('{MODE_PIXEL, 8'h55});
    stim_q.push_back('{MODE_PIXEL, 8'hFF});
    stim_q.push_back('{MODE_PIXEL, 8'h01});
    repeat (6) stim_q.push_back('{MODE_FLUSH, 8'h00});
    // full-scale weights, checkerboard
    wait_idle();
    cfg_write(REG_WIDTH, 16'd5);
    cfg_write(REG_HEIGHT, 16'd5);
    set_taps(3);
    for (int i = 0; i < 25; i++) stim_q.push_back('{MODE_PIXEL, i[0] ? 8'hFF : 8'h00});
    repeat (24) stim_q.push_back('{MODE_FLUSH, 8'h00});

    // tall single-column frame, wraps the row ring
    run_frame(11'd1, 12'd40, 0, 0);

    // long output stall while the sender keeps offering
    wait_idle();
    hold_req = 1;
    run_frame(11'd12, 12'd10, 1, 1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      idle_sel = idle_e'((ph + 1) % 4);
      pushed = 0;
      while (pushed < 300) begin
        if ($urandom_range(15) == 0)
          run_frame(11'($urandom_range(1) ? 0 : $urandom_range(1, 3)),
                    12'($urandom_range(1) ? 0 : $urandom_range(1, 3)), 4, 1);
        else
          run_frame(11'($urandom_range(9) == 0 ? $urandom_range(17, 40)
                                               : $urandom_range(1, 16)),
                    12'($urandom_range(1, 12)), $urandom_range(4), $urandom_range(2) == 0);
        pushed += stim_q.size();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("gaussian_9x9_border_normalized verification clean");
    end else begin
      $display("gaussian_9x9_border_normalized verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("gaussian_9x9_border_normalized verification failed");
    $finish;
  end

endmodule
